### hdl/dmc_pkg.sv
// Shared types and constants for the limit-switch door motor controller.
// Used by dmc_step and limit_switch_door_motor_controller; depends on nothing.
package dmc_pkg;

    // Motion state, one-hot.
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'b001,
        MODE_OPENING = 3'b010,
        MODE_CLOSING = 3'b100
    } t_mode;

    // Move completion codes.
    localparam logic [1:0] RESULT_NONE    = 2'd0;
    localparam logic [1:0] RESULT_LIMIT   = 2'd1;
    localparam logic [1:0] RESULT_TIMEOUT = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_OPEN_TIMEOUT  = 2'd0;
    localparam logic [1:0] REG_CLOSE_TIMEOUT = 2'd1;
    localparam logic [1:0] REG_DRIVE_DUTY    = 2'd2;
    localparam logic [1:0] REG_CONFIRM_TICKS = 2'd3;

    // Configuration reset values.
    localparam logic [15:0] OPEN_TIMEOUT_RST  = 16'd3500;
    localparam logic [15:0] CLOSE_TIMEOUT_RST = 16'd3400;
    localparam logic [7:0]  DRIVE_DUTY_RST    = 8'd85;
    localparam logic [7:0]  CONFIRM_TICKS_RST = 8'd50;

    // Control flags carried from tick to tick.
    typedef struct packed {
        logic       door_open;
        logic       pend_open;
        logic       pend_close;
        logic       close_fired;
        logic       open_fired;
        logic       sw_level;
        logic       limits_known;
        logic [1:0] last_limits;
        logic [7:0] confirm_count;
    } t_flags;

    // One input item.
    typedef struct packed {
        logic open_limit_n;
        logic closed_limit_n;
        logic manual_level;
        logic remote_valid;
        logic remote_open;
        logic open_window;
        logic close_window;
    } t_item;

    // Configuration register set.
    typedef struct packed {
        logic [15:0] open_timeout;
        logic [15:0] close_timeout;
        logic [7:0]  drive_duty;
        logic [7:0]  confirm_ticks;
    } t_cfg;

endpackage

### hdl/dmc_step.sv
// Next-state and result logic for one tick of the door motor controller.
// Depends on dmc_pkg for the mode type, flag, item and configuration structs.
module dmc_step #(
    parameter int TIMER_WIDTH = 16
) (
    input  dmc_pkg::t_item          i_item,
    input  dmc_pkg::t_cfg           i_cfg,
    input  dmc_pkg::t_mode          i_mode,
    input  logic [TIMER_WIDTH-1:0]  i_timer,
    input  dmc_pkg::t_flags         i_flags,
    output dmc_pkg::t_mode          o_mode,
    output logic [TIMER_WIDTH-1:0]  o_timer,
    output dmc_pkg::t_flags         o_flags,
    output logic                    o_drive_open,
    output logic                    o_drive_close,
    output logic [7:0]              o_pwm_duty,
    output logic                    o_door_is_open,
    output logic                    o_report,
    output logic [1:0]              o_move_result
);

    localparam int CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
    localparam logic [CW-1:0] TMAX = CW'((64'd1 << TIMER_WIDTH) - 64'd1);
    localparam logic [TIMER_WIDTH-1:0] TIMER_FULL = {TIMER_WIDTH{1'b1}};

    logic            open_act;
    logic            closed_act;
    logic            opening;
    logic            at_limit;
    logic [CW-1:0]   limit_ext;
    logic [CW-1:0]   timer_ext;
    logic [TIMER_WIDTH-1:0] timer_inc;
    logic [1:0]      limits;

    assign open_act   = ~i_item.open_limit_n;
    assign closed_act = ~i_item.closed_limit_n;
    assign opening    = (i_mode == dmc_pkg::MODE_OPENING);
    assign at_limit   = opening ? open_act : closed_act;
    assign limits     = {i_item.closed_limit_n, i_item.open_limit_n};
    assign timer_inc  = (i_timer == TIMER_FULL) ? i_timer : i_timer + 1'b1;
    assign timer_ext  = CW'(timer_inc);

    // A timeout beyond the timer's range counts as the timer's maximum.
    always_comb begin
        logic [CW-1:0] raw;
        raw = opening ? CW'(i_cfg.open_timeout) : CW'(i_cfg.close_timeout);
        limit_ext = (raw > TMAX) ? TMAX : raw;
    end

    always_comb begin
        o_mode        = i_mode;
        o_timer       = i_timer;
        o_flags       = i_flags;
        o_report      = 1'b0;
        o_move_result = dmc_pkg::RESULT_NONE;

        unique case (i_mode) inside
            dmc_pkg::MODE_OPENING, dmc_pkg::MODE_CLOSING: begin
                o_timer = timer_inc;
                if (at_limit) begin
                    o_move_result = dmc_pkg::RESULT_LIMIT;
                end else if (timer_ext >= limit_ext) begin
                    o_move_result = dmc_pkg::RESULT_TIMEOUT;
                end
                if (o_move_result != dmc_pkg::RESULT_NONE) begin
                    o_mode            = dmc_pkg::MODE_IDLE;
                    o_timer           = '0;
                    o_flags.door_open = opening;
                    if (open_act) o_flags.door_open = 1'b1;
                    if (closed_act) o_flags.door_open = 1'b0;
                    o_report = 1'b1;
                end
            end
            default: begin
                o_mode = dmc_pkg::MODE_IDLE;
                if (!i_flags.limits_known || limits != i_flags.last_limits) begin
                    o_flags.limits_known = 1'b1;
                    o_flags.last_limits  = limits;
                    if (open_act) o_flags.door_open = 1'b1;
                    if (closed_act) o_flags.door_open = 1'b0;
                    o_report = 1'b1;
                end
                // Each scheduled trigger re-arms at the opposite limit.
                if (open_act) begin
                    o_flags.open_fired = 1'b0;
                    if (i_item.close_window && !i_flags.close_fired) begin
                        o_flags.pend_close  = 1'b1;
                        o_flags.close_fired = 1'b1;
                    end
                end
                if (closed_act) begin
                    o_flags.close_fired = 1'b0;
                    if (i_item.open_window && !i_flags.open_fired) begin
                        o_flags.pend_open  = 1'b1;
                        o_flags.open_fired = 1'b1;
                    end
                end
                if (i_item.manual_level != i_flags.sw_level) begin
                    if (i_flags.confirm_count >= i_cfg.confirm_ticks) begin
                        o_flags.sw_level      = i_item.manual_level;
                        o_flags.confirm_count = '0;
                        if (o_flags.door_open) begin
                            if (!closed_act) o_flags.pend_close = 1'b1;
                        end else begin
                            if (!open_act) o_flags.pend_open = 1'b1;
                        end
                    end else begin
                        o_flags.confirm_count = i_flags.confirm_count + 8'd1;
                    end
                end else begin
                    o_flags.confirm_count = '0;
                end
                // Close wins; a pending open waits for the next idle tick.
                if (o_flags.pend_close) begin
                    o_flags.pend_close = 1'b0;
                    o_mode             = dmc_pkg::MODE_CLOSING;
                    o_timer            = '0;
                end else if (o_flags.pend_open) begin
                    o_flags.pend_open = 1'b0;
                    o_mode            = dmc_pkg::MODE_OPENING;
                    o_timer           = '0;
                end
            end
        endcase

        if (i_item.remote_valid) begin
            if (i_item.remote_open) o_flags.pend_open = 1'b1;
            else o_flags.pend_close = 1'b1;
        end
    end

    assign o_drive_open   = (o_mode == dmc_pkg::MODE_OPENING);
    assign o_drive_close  = (o_mode == dmc_pkg::MODE_CLOSING);
    assign o_pwm_duty     = (o_mode != dmc_pkg::MODE_IDLE) ? i_cfg.drive_duty : 8'd0;
    assign o_door_is_open = o_flags.door_open;

endmodule

### hdl/limit_switch_door_motor_controller.sv
// A transfer accepted at a clock edge shows its result in the result register after that edge.
// Throughput: one tick per cycle; the tick logic runs from the input port and state
// straight into the result register, and input stalls only while that register is
// full and the downstream side stalls.
// Reset (synchronous, active low): idle, door believed closed, nothing pending,
// configuration at its defaults, and the first idle tick reports the limits.
module limit_switch_door_motor_controller #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_open_limit_n,
    input  logic        i_closed_limit_n,
    input  logic        i_manual_level,
    input  logic        i_remote_valid,
    input  logic        i_remote_open,
    input  logic        i_open_window,
    input  logic        i_close_window,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_drive_open,
    output logic        o_drive_close,
    output logic [7:0]  o_pwm_duty,
    output logic        o_door_is_open,
    output logic        o_report,
    output logic [1:0]  o_move_result
);

    dmc_pkg::t_cfg          r_cfg;
    dmc_pkg::t_mode         r_mode;
    dmc_pkg::t_mode         n_mode;
    logic [TIMER_WIDTH-1:0] r_timer;
    logic [TIMER_WIDTH-1:0] n_timer;
    dmc_pkg::t_flags        r_flags;
    dmc_pkg::t_flags        n_flags;
    dmc_pkg::t_item         item;

    logic       r_out_valid;
    logic       r_drive_open, r_drive_close, r_door_is_open, r_report;
    logic [7:0] r_pwm_duty;
    logic [1:0] r_move_result;
    logic       n_drive_open, n_drive_close, n_door_is_open, n_report;
    logic [7:0] n_pwm_duty;
    logic [1:0] n_move_result;
    logic       accept;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    assign item = '{open_limit_n:   i_open_limit_n,
                    closed_limit_n: i_closed_limit_n,
                    manual_level:   i_manual_level,
                    remote_valid:   i_remote_valid,
                    remote_open:    i_remote_open,
                    open_window:    i_open_window,
                    close_window:   i_close_window};

    dmc_step #(.TIMER_WIDTH(TIMER_WIDTH)) u_step (
        .i_item        (item),
        .i_cfg         (r_cfg),
        .i_mode        (r_mode),
        .i_timer       (r_timer),
        .i_flags       (r_flags),
        .o_mode        (n_mode),
        .o_timer       (n_timer),
        .o_flags       (n_flags),
        .o_drive_open  (n_drive_open),
        .o_drive_close (n_drive_close),
        .o_pwm_duty    (n_pwm_duty),
        .o_door_is_open(n_door_is_open),
        .o_report      (n_report),
        .o_move_result (n_move_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{open_timeout:  dmc_pkg::OPEN_TIMEOUT_RST,
                       close_timeout: dmc_pkg::CLOSE_TIMEOUT_RST,
                       drive_duty:    dmc_pkg::DRIVE_DUTY_RST,
                       confirm_ticks: dmc_pkg::CONFIRM_TICKS_RST};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dmc_pkg::REG_OPEN_TIMEOUT:  r_cfg.open_timeout  <= i_cfg_data;
                dmc_pkg::REG_CLOSE_TIMEOUT: r_cfg.close_timeout <= i_cfg_data;
                dmc_pkg::REG_DRIVE_DUTY:    r_cfg.drive_duty    <= i_cfg_data[7:0];
                dmc_pkg::REG_CONFIRM_TICKS: r_cfg.confirm_ticks <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode                <= dmc_pkg::MODE_IDLE;
            r_timer               <= '0;
            r_flags               <= '{sw_level: 1'b1, default: '0};
            r_out_valid           <= 1'b0;
        end else begin
            if (accept) begin
                r_mode  <= n_mode;
                r_timer <= n_timer;
                r_flags <= n_flags;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register; it only loads on an accepted transfer.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_drive_open   <= n_drive_open;
            r_drive_close  <= n_drive_close;
            r_pwm_duty     <= n_pwm_duty;
            r_door_is_open <= n_door_is_open;
            r_report       <= n_report;
            r_move_result  <= n_move_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_drive_open   = r_drive_open;
    assign o_drive_close  = r_drive_close;
    assign o_pwm_duty     = r_pwm_duty;
    assign o_door_is_open = r_door_is_open;
    assign o_report       = r_report;
    assign o_move_result  = r_move_result;

endmodule
